@@ design/iec_bus_device_command_decoder_core_macros.svh @@
// Assertion shorthands shared by the decoder RTL.
`ifndef IEC_BUS_DEVICE_COMMAND_DECODER_CORE_MACROS_SVH
`define IEC_BUS_DEVICE_COMMAND_DECODER_CORE_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define IEC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies consequence in the next.
`define IEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/iecdec_pkg.sv @@
`timescale 1ns / 1ps

package iecdec_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_W       = 4;
    localparam int BUFNUM_W     = 3;
    localparam int DEV_W        = 5;

    localparam logic [BUFNUM_W-1:0] NO_BUFFER   = 3'd7;
    localparam logic [CHAN_W-1:0]   CMD_CHANNEL = 4'd15;
    localparam logic [DEV_W-1:0]    DEVICE_RESET = 5'd8;

    // Bus command codes
    localparam logic [7:0] LISTEN_BASE = 8'h20;
    localparam logic [7:0] TALK_BASE   = 8'h40;
    localparam logic [7:0] UNLISTEN    = 8'h3F;
    localparam logic [7:0] UNTALK      = 8'h5F;

    // High nibble of secondary addresses
    localparam logic [3:0] SEC_DATA  = 4'h6;
    localparam logic [3:0] SEC_CLOSE = 4'hE;
    localparam logic [3:0] SEC_OPEN  = 4'hF;

    // Result transaction, first member in the highest bits
    typedef struct packed {
        logic                pad;
        logic                buffer_released;
        logic [BUFNUM_W-1:0] buffer_of_channel;
        logic                open_failed;
        logic                error_readout_active;
        logic                error_readout_start;
        logic                name_done;
        logic [7:0]          name_byte;
        logic                name_byte_valid;
        logic [CHAN_W-1:0]   channel;
        logic                is_talking;
        logic                is_listening;
    } result_t;

endpackage

@@ design/iec_bus_device_command_decoder_core.sv @@
`timescale 1ns / 1ps
`include "iec_bus_device_command_decoder_core_macros.svh"

// Command decoder of a disk drive on a serial peripheral bus.
// Input stream (s_*): one bus byte per transaction, together with a flag
// telling whether the command channel buffer has been read out.
// Output stream (m_*): one result per input byte with the bus flags, the
// current channel, the name byte being collected, open/close outcome and
// the buffer number of the current channel.
// Configuration: cfg_we/cfg_wdata write the drive's bus address; write it
// only while no transaction is in flight.
// The byte is decoded against the channel table in the cycle it is
// accepted and the result sits in the output register at the next edge.
// Throughput is one byte per cycle while the receiver does not stall; the
// decode and the first-free buffer search are one combinational pass.
// s_tready stays high while the output register is empty or being drained,
// so a stalled receiver holds one result and then back-pressures the input.
// Reset clears flags, closes all channels, frees all buffers and sets the
// bus address to 8.
module iec_bus_device_command_decoder_core #(
    parameter int NUM_BUFFERS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,     // device_number
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [7:0] bus_byte, [8] cmd_buffer_drained
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] is_listening, [1] is_talking, [5:2] channel, [6] name_byte_valid,
    // [14:7] name_byte, [15] name_done, [16] error_readout_start,
    // [17] error_readout_active, [18] open_failed, [21:19] buffer_of_channel,
    // [22] buffer_released
    output logic [23:0] m_tdata
);

    localparam int USE_W = NUM_BUFFERS + 1;

    logic [iecdec_pkg::DEV_W-1:0]    device_number_reg;
    logic                            listen_reg, listen_next;
    logic                            talk_reg, talk_next;
    logic [iecdec_pkg::CHAN_W-1:0]   channel_reg, channel_next;
    logic                            collecting_reg, collecting_next;
    logic                            err_trig_reg, err_trig_next;
    logic [iecdec_pkg::BUFNUM_W-1:0] chan_buf_reg  [iecdec_pkg::NUM_CHANNELS];
    logic [iecdec_pkg::BUFNUM_W-1:0] chan_buf_next [iecdec_pkg::NUM_CHANNELS];
    logic [iecdec_pkg::NUM_CHANNELS-1:0] chan_open_reg, chan_open_next;
    logic [iecdec_pkg::NUM_CHANNELS-1:0] chan_named_reg, chan_named_next;
    logic [USE_W-1:0]                in_use_reg, in_use_next;

    logic                    out_valid_reg;
    iecdec_pkg::result_t     out_data_reg;
    iecdec_pkg::result_t     res;

    logic                    s_accept;
    logic [7:0]              bus_byte;
    logic                    drained;
    logic [3:0]              nib;
    logic [3:0]              hi;
    logic [7:0]              listen_code;
    logic [7:0]              talk_code;
    logic                    free_found;
    logic [iecdec_pkg::BUFNUM_W-1:0] free_idx;
    logic [iecdec_pkg::BUFNUM_W-1:0] own_buf;
    logic [iecdec_pkg::BUFNUM_W-1:0] cmd_buf;

    assign s_accept    = s_tvalid && s_tready;
    assign s_tready    = !out_valid_reg || m_tready;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;
    assign bus_byte    = s_tdata[7:0];
    assign drained     = s_tdata[8];
    assign nib         = bus_byte[3:0];
    assign hi          = bus_byte[7:4];
    assign listen_code = iecdec_pkg::LISTEN_BASE + {3'b000, device_number_reg};
    assign talk_code   = iecdec_pkg::TALK_BASE + {3'b000, device_number_reg};
    assign own_buf     = chan_buf_reg[nib];
    assign cmd_buf     = iecdec_pkg::BUFNUM_W'(NUM_BUFFERS);

    // Lowest free general buffer
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = iecdec_pkg::NO_BUFFER;
        for (int b = NUM_BUFFERS - 1; b >= 0; b--)
        begin
            if (!in_use_reg[b])
            begin
                free_found = 1'b1;
                free_idx   = iecdec_pkg::BUFNUM_W'(b);
            end
        end
    end

    always_comb
    begin
        listen_next     = listen_reg;
        talk_next       = talk_reg;
        channel_next    = channel_reg;
        collecting_next = collecting_reg;
        err_trig_next   = err_trig_reg;
        chan_buf_next   = chan_buf_reg;
        chan_open_next  = chan_open_reg;
        chan_named_next = chan_named_reg;
        in_use_next     = in_use_reg;
        res             = '0;

        if (collecting_reg)
        begin
            if (bus_byte == iecdec_pkg::UNLISTEN)
            begin
                collecting_next = 1'b0;
                res.name_done   = 1'b1;
            end
            else
            begin
                res.name_byte_valid = 1'b1;
                res.name_byte       = bus_byte;
            end
        end

        // End of name falls through to command decode
        if (!collecting_next)
        begin
            if (bus_byte == listen_code)
            begin
                listen_next = 1'b1;
                talk_next   = 1'b0;
            end
            else if (bus_byte == iecdec_pkg::UNLISTEN)
            begin
                listen_next = 1'b0;
            end
            else if (bus_byte == talk_code)
            begin
                talk_next   = 1'b1;
                listen_next = 1'b0;
            end
            else if (bus_byte == iecdec_pkg::UNTALK)
            begin
                err_trig_next = 1'b0;
                talk_next     = 1'b0;
            end
            else if (hi == iecdec_pkg::SEC_DATA)
            begin
                channel_next = nib;
                if (nib == iecdec_pkg::CMD_CHANNEL && drained)
                begin
                    if (talk_reg)
                    begin
                        res.error_readout_start = 1'b1;
                        chan_named_next[nib]    = 1'b0;
                        chan_open_next[nib]     = 1'b1;
                        err_trig_next           = 1'b1;
                    end
                    else if (listen_reg)
                    begin
                        if (own_buf == iecdec_pkg::NO_BUFFER)
                        begin
                            chan_buf_next[nib]       = cmd_buf;
                            in_use_next[NUM_BUFFERS] = 1'b1;
                        end
                        chan_named_next[nib] = 1'b1;
                        chan_open_next[nib]  = 1'b1;
                        collecting_next      = 1'b1;
                    end
                end
            end
            else if (hi == iecdec_pkg::SEC_CLOSE)
            begin
                channel_next = nib;
                if (own_buf <= cmd_buf)
                begin
                    in_use_next[own_buf] = 1'b0;
                    chan_buf_next[nib]   = iecdec_pkg::NO_BUFFER;
                    res.buffer_released  = 1'b1;
                end
                chan_named_next[nib] = 1'b0;
                chan_open_next[nib]  = 1'b0;
            end
            else if (hi == iecdec_pkg::SEC_OPEN)
            begin
                channel_next = nib;
                if (own_buf != iecdec_pkg::NO_BUFFER || nib == iecdec_pkg::CMD_CHANNEL
                    || free_found)
                begin
                    if (own_buf == iecdec_pkg::NO_BUFFER)
                    begin
                        if (nib == iecdec_pkg::CMD_CHANNEL)
                        begin
                            chan_buf_next[nib]       = cmd_buf;
                            in_use_next[NUM_BUFFERS] = 1'b1;
                        end
                        else
                        begin
                            chan_buf_next[nib]    = free_idx;
                            in_use_next[free_idx] = 1'b1;
                        end
                    end
                    chan_named_next[nib] = 1'b1;
                    chan_open_next[nib]  = 1'b1;
                    collecting_next      = 1'b1;
                end
                else
                begin
                    chan_open_next[nib] = 1'b0;
                    res.open_failed     = 1'b1;
                end
            end
        end

        res.is_listening         = listen_next;
        res.is_talking           = talk_next;
        res.channel              = channel_next;
        res.error_readout_active = err_trig_next;
        res.buffer_of_channel    = chan_buf_next[channel_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_number_reg <= iecdec_pkg::DEVICE_RESET;
        end
        else if (cfg_we)
        begin
            device_number_reg <= cfg_wdata;
        end
    end

    // Advance decoder state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_reg     <= 1'b0;
            talk_reg       <= 1'b0;
            channel_reg    <= '0;
            collecting_reg <= 1'b0;
            err_trig_reg   <= 1'b0;
            chan_open_reg  <= '0;
            chan_named_reg <= '0;
            in_use_reg     <= '0;
            for (int i = 0; i < iecdec_pkg::NUM_CHANNELS; i++)
            begin
                chan_buf_reg[i] <= iecdec_pkg::NO_BUFFER;
            end
        end
        else if (s_accept)
        begin
            listen_reg     <= listen_next;
            talk_reg       <= talk_next;
            channel_reg    <= channel_next;
            collecting_reg <= collecting_next;
            err_trig_reg   <= err_trig_next;
            chan_open_reg  <= chan_open_next;
            chan_named_reg <= chan_named_next;
            in_use_reg     <= in_use_next;
            chan_buf_reg   <= chan_buf_next;
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            out_data_reg <= res;
        end
    end

    `IEC_ASSERT(a_named_is_open, (chan_named_reg & ~chan_open_reg) == '0,
        "named channel is not open")
    `IEC_ASSERT(a_cmd_chan_buf,
        chan_buf_reg[iecdec_pkg::CMD_CHANNEL] == iecdec_pkg::NO_BUFFER ||
        chan_buf_reg[iecdec_pkg::CMD_CHANNEL] == cmd_buf,
        "command channel holds a general buffer")
    `IEC_ASSERT_NEXT(a_name_byte_passed,
        s_accept && collecting_reg && bus_byte != iecdec_pkg::UNLISTEN,
        m_tvalid && out_data_reg.name_byte_valid && out_data_reg.name_byte == $past(bus_byte),
        "name byte not passed to output")
    `IEC_ASSERT(a_result_exclusive,
        !(out_valid_reg && out_data_reg.name_byte_valid &&
          (out_data_reg.open_failed || out_data_reg.buffer_released ||
           out_data_reg.error_readout_start || out_data_reg.name_done)),
        "name byte result also carries a command outcome")

endmodule
